### design/kpa_pkg.sv
// ----------------------------------------------------------------------------
// kpa_pkg
// Shared types and constants for the keyed position accumulator: word widths
// and the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package kpa_pkg;

    // word widths fixed by the item fields
    localparam int KEY_LOW_W  = 64;
    localparam int KEY_HIGH_W = 8;
    localparam int KEY_W      = KEY_LOW_W + KEY_HIGH_W;
    localparam int AMOUNT_W   = 32;
    localparam int TOTAL_W    = 64;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture the input word, restart the scan
        logic scan;      // issue a read at the scan index
        logic wr_hit;    // update the matching total and report it
        logic wr_new;    // append a new entry and report it
        logic rep_full;  // report a miss on a full table
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_end;  // every valid entry has been read
        logic rd_valid;  // read data of a scanned entry is present
        logic match;     // read data holds the wanted key
        logic full;      // no free entry left
    } status_t;

endpackage

### design/kpa_ctrl.sv
// ----------------------------------------------------------------------------
// kpa_ctrl
// Controller of the keyed position accumulator: accepts a word, steps the
// table scan and picks hit update, append or full report.
// ----------------------------------------------------------------------------
module kpa_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  kpa_pkg::status_t status,
    output kpa_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.match)
                begin
                    cmd.wr_hit = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!status.rd_valid && status.scan_end)
                begin
                    if (status.full)
                        cmd.rep_full = 1'b1;
                    else
                        cmd.wr_new = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!status.scan_end)
                begin
                    cmd.scan = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### design/kpa_datapath.sv
// ----------------------------------------------------------------------------
// kpa_datapath
// Datapath of the keyed position accumulator: key and total memories, scan
// index, entry count, key compare, total adder and result registers.
// ----------------------------------------------------------------------------
module kpa_datapath
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  kpa_pkg::cmd_t                         cmd,
    output kpa_pkg::status_t                      status,
    input  logic        [kpa_pkg::KEY_LOW_W-1:0]  key_low,
    input  logic        [kpa_pkg::KEY_HIGH_W-1:0] key_high,
    input  logic                                  is_buy,
    input  logic signed [kpa_pkg::AMOUNT_W-1:0]   amount,
    output logic                                  done,
    output logic signed [kpa_pkg::TOTAL_W-1:0]    new_total,
    output logic                                  was_found,
    output logic                                  table_full
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] LAST_COUNT = CW'(TABLE_ENTRIES);

    localparam int KW = kpa_pkg::KEY_W;
    localparam int TW = kpa_pkg::TOTAL_W;

    // zero every byte after the first zero byte of the key
    function automatic logic [KW-1:0] norm_key(input logic [kpa_pkg::KEY_LOW_W-1:0] lo,
                                               input logic [kpa_pkg::KEY_HIGH_W-1:0] hi);
        logic       alive;
        logic [KW-1:0] res;
        alive = 1'b1;
        res   = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (lo[8*i +: 8] == 8'h00)
                alive = 1'b0;
            res[8*i +: 8] = alive ? lo[8*i +: 8] : 8'h00;
        end
        res[KW-1 -: kpa_pkg::KEY_HIGH_W] = alive ? hi : '0;
        return res;
    endfunction

    logic [KW-1:0] key_mem [TABLE_ENTRIES];
    logic [TW-1:0] total_mem [TABLE_ENTRIES];

    logic [KW-1:0] key_reg;
    logic [TW-1:0] delta_reg;
    logic [TW-1:0] delta_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] scan_idx_reg;
    logic [AW-1:0] rd_addr_reg;
    logic          rd_valid_reg;
    logic [KW-1:0] rd_key_reg;
    logic [TW-1:0] rd_total_reg;
    logic [TW-1:0] sum;

    logic                 done_reg;
    logic signed [TW-1:0] total_reg;
    logic                 found_reg;
    logic                 full_reg;

    // signed delta: sign-extended amount, negated for a sell
    always_comb
    begin
        delta_next = {{(TW - kpa_pkg::AMOUNT_W){amount[kpa_pkg::AMOUNT_W-1]}}, amount};
        if (!is_buy)
            delta_next = TW'(0) - delta_next;
    end

    // captured word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= norm_key(key_low, key_high);
            delta_reg <= delta_next;
        end
    end

    // scan index and read-valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan;
            if (cmd.scan)
                scan_idx_reg <= scan_idx_reg + CW'(1);
        end
    end

    // memory reads along the scan
    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            rd_addr_reg  <= scan_idx_reg[AW-1:0];
            rd_key_reg   <= key_mem[scan_idx_reg[AW-1:0]];
            rd_total_reg <= total_mem[scan_idx_reg[AW-1:0]];
        end
    end

    // memory writes: append or hit update
    always_ff @(posedge clk)
    begin
        if (cmd.wr_new)
        begin
            key_mem[count_reg[AW-1:0]]   <= key_reg;
            total_mem[count_reg[AW-1:0]] <= delta_reg;
        end
        else if (cmd.wr_hit)
        begin
            total_mem[rd_addr_reg] <= sum;
        end
    end

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.wr_new)
            count_reg <= count_reg + CW'(1);
    end

    assign sum = rd_total_reg + delta_reg;

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.wr_hit | cmd.wr_new | cmd.rep_full;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_hit)
        begin
            total_reg <= sum;
            found_reg <= 1'b1;
            full_reg  <= 1'b0;
        end
        else if (cmd.wr_new)
        begin
            total_reg <= delta_reg;
            found_reg <= 1'b0;
            full_reg  <= 1'b0;
        end
        else if (cmd.rep_full)
        begin
            total_reg <= '0;
            found_reg <= 1'b0;
            full_reg  <= 1'b1;
        end
    end

    // status to the controller
    assign status.scan_end = (scan_idx_reg == count_reg);
    assign status.rd_valid = rd_valid_reg;
    assign status.match    = rd_valid_reg && (rd_key_reg == key_reg);
    assign status.full     = (count_reg == LAST_COUNT);

    assign done       = done_reg;
    assign new_total  = total_reg;
    assign was_found  = found_reg;
    assign table_full = full_reg;

endmodule

### design/keyed_position_accumulator.sv
// ----------------------------------------------------------------------------
// keyed_position_accumulator
// Keeps a signed 64-bit running total per key in a table filled in arrival
// order; each word adds or subtracts its amount and reports the new total.
// ----------------------------------------------------------------------------
// Usage:
//   A word (key_low, key_high, is_buy, amount) is taken at a rising edge with
//   start high and busy low. Key bytes after the first zero byte are ignored.
//   One result word per input: done is high for exactly one cycle with
//   new_total, was_found and table_full valid in that cycle. The receiver
//   cannot stall; results must be taken when done is high.
// Timing:
//   The scan reads one stored key per cycle from entry 0 upward; a miss reads
//   every stored entry and a hit stops at the matching entry. The read data
//   is registered, and the compare sees it in the cycle after the read.
//   busy falls with done, so the next start may be given in the cycle that
//   done is shown.
// Reset:
//   rst_n empties the table at once (entry count zero); no clearing pass.
// ----------------------------------------------------------------------------
module keyed_position_accumulator
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic        [kpa_pkg::KEY_LOW_W-1:0]  key_low,
    input  logic        [kpa_pkg::KEY_HIGH_W-1:0] key_high,
    input  logic                                  is_buy,
    input  logic signed [kpa_pkg::AMOUNT_W-1:0]   amount,
    output logic                                  done,
    output logic signed [kpa_pkg::TOTAL_W-1:0]    new_total,
    output logic                                  was_found,
    output logic                                  table_full
);

    kpa_pkg::cmd_t    cmd;
    kpa_pkg::status_t status;

    // controller
    kpa_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // datapath
    kpa_datapath
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .key_low    (key_low),
        .key_high   (key_high),
        .is_buy     (is_buy),
        .amount     (amount),
        .done       (done),
        .new_total  (new_total),
        .was_found  (was_found),
        .table_full (table_full)
    );

endmodule
